// File: rtl/ucd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and the sequence-length function.
// ----------------------------------------------------------------------------
package ucd_pkg;

  localparam int WinDepth = 4;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  typedef logic [2:0] cnt_t;
  typedef logic [7:0] octet_t;
  typedef logic [WinDepth-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        run_end;
    logic        text_end;
  } out_item_t;

  // one result offered by the window to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  // sequence length from the lead byte
  function automatic cnt_t seq_len(input octet_t lead);
    cnt_t len;
    priority if (lead >= 8'hF0) begin
      len = 3'd4;
    end else if (lead >= 8'hE0) begin
      len = 3'd3;
    end else if (lead >= 8'hC0) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

// File: rtl/ucd_seq_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 head sequence decoder
// Decodes the sequence that starts at the head of the window: length,
// well-formedness of lead and continuation bytes, and the assembled value.
// ----------------------------------------------------------------------------
module ucd_seq_dec
  import ucd_pkg::*;
(
  input  win_t        win,
  output cnt_t        len,
  output logic        well_formed,
  output logic [20:0] cp
);

  logic lead_ok;
  logic [3:1] cont_ok;

  always_comb begin
    len     = seq_len(win[0]);
    lead_ok = (win[0][7:6] != 2'b10);
    for (int i = 1; i < WinDepth; i++) begin
      cont_ok[i] = (win[i][7:6] == 2'b10);
    end
    well_formed = lead_ok
                  && (len < 3'd2 || cont_ok[1])
                  && (len < 3'd3 || cont_ok[2])
                  && (len < 3'd4 || cont_ok[3]);

    unique case (len)
      3'd4:    cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
      3'd3:    cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
      3'd2:    cp = {10'd0, win[0][4:0], win[1][5:0]};
      default: cp = {13'd0, win[0]};
    endcase
  end

endmodule

// File: rtl/ucd_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 pending byte window
// Holds the bytes of the pending sequence, offers one result per cycle while the
// output register has room, and takes a new byte once the current byte's results are all out.
// ----------------------------------------------------------------------------
module ucd_window
  import ucd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     slot_free,
  output emit_t    emit
);

  win_t win_r, win_nxt;
  cnt_t cnt_r, cnt_nxt;
  logic fin_r, fin_nxt;

  cnt_t        head_len;
  logic        head_ok;
  logic [20:0] head_cp;

  logic complete, busy, emit_fire, accept, rem_busy;
  cnt_t drop, post_cnt, base_cnt;
  win_t shifted, base_win;
  logic [2:0] src;

  ucd_seq_dec u_head_dec (
    .win         (win_r),
    .len         (head_len),
    .well_formed (head_ok),
    .cp          (head_cp)
  );

  always_comb begin
    complete  = (head_len <= cnt_r);
    busy      = (cnt_r != 3'd0) && (complete || fin_r);
    emit_fire = busy && slot_free;
    drop      = head_ok ? head_len : 3'd1;

    // window as it stands after the head result goes out
    for (int k = 0; k < WinDepth; k++) begin
      src = 3'(k) + drop;
      shifted[k] = (src < 3'(WinDepth)) ? win_r[src[1:0]] : 8'h00;
    end
    // truncated sequence at end of text flushes the window
    post_cnt = complete ? (cnt_r - drop) : 3'd0;
    rem_busy = (post_cnt != 3'd0) && ((seq_len(shifted[0]) <= post_cnt) || fin_r);

    in_ready = !busy || (slot_free && !rem_busy);
    accept   = in_valid && in_ready;

    base_win = emit_fire ? shifted : win_r;
    base_cnt = emit_fire ? post_cnt : cnt_r;

    win_nxt = base_win;
    cnt_nxt = base_cnt;
    fin_nxt = fin_r;
    if (accept) begin
      win_nxt[base_cnt[1:0]] = in_data.text_byte;
      cnt_nxt = base_cnt + 3'd1;
      fin_nxt = in_data.final_byte;
    end

    emit.valid           = busy;
    emit.item.code_point = (complete && head_ok) ? head_cp : REPL_CP;
    emit.item.run_end    = !rem_busy;
    emit.item.text_end   = !rem_busy && fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      fin_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(WinDepth))
    else $error("window count out of range");

  a_append_fits: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> base_cnt < 3'(WinDepth))
    else $error("byte appended to a full window");

  a_text_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && fin_r && !rem_busy && !accept) |=> cnt_r == 3'd0)
    else $error("window not empty after end of text");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !slot_free) |-> !in_ready)
    else $error("byte taken while a result is blocked");

endmodule

// File: rtl/utf8_codepoint_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 code point decoder
// Turns a UTF-8 byte stream into code points, U+FFFD for malformed input.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one text byte per transaction,
// final_byte marks the last byte of a text. Output channel
// (out_valid/out_ready/out_data): one code point per transaction, run_end on
// the last result of an input byte, text_end on the last result of a text.
// A byte that does not finish a sequence or a text produces no result.
// A byte is written into the pending window register when it is accepted, and its
// first result passes into the output register once that register is free.
// Throughput: one byte per cycle while each byte yields at most one result and
// the output register is free; a byte that yields several results (bad
// continuation resync, truncated tail) holds the input until the extra results
// are out, since the output register takes one result per cycle.
// A stalled receiver does not block bytes that only extend a pending
// sequence; a ready result waits in the output register.
// Reset (synchronous, rst_n low) empties the window and the output register.
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit
  import ucd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  emit_t     emit;
  logic      slot_free;
  logic      take;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  ucd_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .slot_free (slot_free),
    .emit      (emit)
  );

  always_comb begin
    slot_free     = !out_valid_r || out_ready;
    take          = emit.valid && slot_free;
    out_valid_nxt = take || (out_valid_r && !out_ready);
    out_data_nxt  = take ? emit.item : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
